[design/assert_macros.svh]
// assertion macros for the clipper core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("assert fail");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assert fail");
`else
`define ASSERT_IMPL(label, cond)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/elc_pkg.sv]
package elc_pkg;
  localparam int SampleWidth = 16;
  localparam int DelayDepth = 64;
  localparam int PtrWidth = $clog2(DelayDepth);
  localparam int OneLevel = 1 << (SampleWidth - 4);
  // dividend is mag*ONE: sample width + frac bits
  localparam int DivWidth = SampleWidth + SampleWidth - 4;
  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [SampleWidth-1:0] env_t;
endpackage

[design/envelope_lookahead_clipper_core.sv]
// channel | handshake             | fields
// input   | in_valid / in_ready   | in_sample_i, in_sample_q
// result  | out_valid / out_ready | out_delayed_i, out_delayed_q, out_excess_i, out_excess_q
// one item runs: accept in idle, read, 16 root steps, peak, two 28-step divides (I then Q,
// each after its load state) and the output state, all on one shared compare-subtract unit
// in_ready is high only in idle; a result waiting in the output registers lets the
// next item run and stalls it only in its output cycle until the result is taken
// reset (rst_n low, synchronous) clears pointers, envelope ring and the delay valid
// bits; delay entries never written read as zero through those per-entry valid bits
module envelope_lookahead_clipper_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [elc_pkg::SampleWidth-1:0] in_sample_i,
  input  logic signed [elc_pkg::SampleWidth-1:0] in_sample_q,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [elc_pkg::SampleWidth-1:0] out_delayed_i,
  output logic signed [elc_pkg::SampleWidth-1:0] out_delayed_q,
  output logic signed [elc_pkg::SampleWidth-1:0] out_excess_i,
  output logic signed [elc_pkg::SampleWidth-1:0] out_excess_q
);
`include "assert_macros.svh"
  localparam int SW = elc_pkg::SampleWidth;
  localparam int DD = elc_pkg::DelayDepth;
  localparam int PW = elc_pkg::PtrWidth;
  localparam int DW = elc_pkg::DivWidth;
  localparam int SHW = 2 * SW;
  localparam int RW = SW + 3;
  localparam int CW = $clog2(DW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_ROOT  = 4'd2;
  localparam logic [3:0] S_PEAK  = 4'd3;
  localparam logic [3:0] S_LOADI = 4'd4;
  localparam logic [3:0] S_DIVI  = 4'd5;
  localparam logic [3:0] S_LOADQ = 4'd6;
  localparam logic [3:0] S_DIVQ  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r;
  logic [PW-1:0] wp_r;
  logic [1:0] ep_r;
  logic [DD-1:0] vld_r;
  elc_pkg::sample_t mem_i [DD];
  elc_pkg::sample_t mem_q [DD];
  elc_pkg::env_t env_r [4];
  elc_pkg::sample_t si_r, sq_r, di_r, dq_r, xi_r, xq_r;
  logic rd_ok_r, pv_ok_r;
  logic [CW-1:0] cnt_r;
  // shared shift-subtract unit state
  logic [SHW-1:0] sh_r;
  logic [RW-1:0] rem_r;
  logic [SW-1:0] acc_r;
  elc_pkg::env_t peak_r;
  elc_pkg::sample_t exi_r;
  elc_pkg::sample_t out_di_r, out_dq_r, out_ei_r, out_eq_r;
  logic out_valid_r;
  logic in_fire, out_load;

  logic [PW-1:0] rd_ptr, pv_ptr;
  assign rd_ptr = (wp_r == PW'(DD - 1)) ? '0 : wp_r + 1'b1;
  assign pv_ptr = (wp_r == '0) ? PW'(DD - 1) : wp_r - 1'b1;

  // square magnitude
  logic [SW-1:0] mi, mq;
  logic [SHW-1:0] mi2, mq2, sq_sum;
  assign mi = si_r[SW-1] ? SW'(-si_r) : SW'(si_r);
  assign mq = sq_r[SW-1] ? SW'(-sq_r) : SW'(sq_r);
  assign mi2 = mi * mi;
  assign mq2 = mq * mq;
  assign sq_sum = mi2 + mq2;

  // shared compare-subtract: root takes two bits a step, divide one
  logic u_root, u_ge;
  logic [RW-1:0] u_a, u_b, u_diff;
  assign u_root = (state_r == S_ROOT);
  assign u_a = u_root ? {rem_r[RW-3:0], sh_r[SHW-1 -: 2]} : {rem_r[RW-2:0], sh_r[SHW-1]};
  assign u_b = u_root ? {{(RW-SW-2){1'b0}}, acc_r, 2'b01} : {{(RW-SW){1'b0}}, peak_r};
  assign u_diff = u_a - u_b;
  assign u_ge = (u_a >= u_b);

  // peak of three newest, floored
  elc_pkg::env_t e0, e1, e2, pk01, pk;
  assign e0 = env_r[ep_r];
  assign e1 = env_r[ep_r - 2'd1];
  assign e2 = env_r[ep_r - 2'd2];
  assign pk01 = (e0 > e1) ? e0 : e1;
  assign pk = (pk01 > e2) ? pk01 : e2;

  // magnitude times one, left aligned in the shift register
  function automatic logic [SHW-1:0] mag_num(input elc_pkg::sample_t x);
    logic [SW-1:0] m;
    m = x[SW-1] ? SW'(-x) : SW'(x);
    return {m, {SW{1'b0}}};
  endfunction

  function automatic elc_pkg::sample_t excess(input elc_pkg::sample_t x,
                                              input logic [SW-1:0] q);
    elc_pkg::sample_t c;
    c = elc_pkg::sample_t'(q);
    return x[SW-1] ? x + c : x - c;
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // delay line memories
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_i[wp_r] <= in_sample_i;
      mem_q[wp_r] <= in_sample_q;
    end
    di_r <= mem_i[rd_ptr];
    dq_r <= mem_q[rd_ptr];
    xi_r <= mem_i[pv_ptr];
    xq_r <= mem_q[pv_ptr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r <= '0;
      ep_r <= '0;
      vld_r <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) env_r[k] <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      unique case (state_r) inside
        S_IDLE: begin
          if (in_fire) begin
            si_r <= in_sample_i;
            sq_r <= in_sample_q;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          rd_ok_r <= vld_r[rd_ptr];
          pv_ok_r <= vld_r[pv_ptr];
          vld_r[wp_r] <= 1'b1;
          sh_r <= sq_sum;
          rem_r <= '0;
          acc_r <= '0;
          cnt_r <= CW'(SW);
          state_r <= S_ROOT;
        end
        S_ROOT, S_DIVI, S_DIVQ: begin
          sh_r <= u_root ? (sh_r << 2) : (sh_r << 1);
          rem_r <= u_ge ? u_diff : u_a;
          acc_r <= {acc_r[SW-2:0], u_ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            if (state_r == S_ROOT) state_r <= S_PEAK;
            else if (state_r == S_DIVI) state_r <= S_LOADQ;
            else state_r <= S_OUT;
          end
        end
        S_PEAK: begin
          env_r[ep_r] <= acc_r;
          state_r <= S_LOADI;
        end
        S_LOADI: begin
          peak_r <= (pk < elc_pkg::env_t'(elc_pkg::OneLevel)) ?
                    elc_pkg::env_t'(elc_pkg::OneLevel) : pk;
          sh_r <= mag_num(pv_ok_r ? xi_r : '0);
          rem_r <= '0;
          acc_r <= '0;
          cnt_r <= CW'(DW);
          state_r <= S_DIVI;
        end
        S_LOADQ: begin
          exi_r <= excess(pv_ok_r ? xi_r : '0, acc_r);
          sh_r <= mag_num(pv_ok_r ? xq_r : '0);
          rem_r <= '0;
          acc_r <= '0;
          cnt_r <= CW'(DW);
          state_r <= S_DIVQ;
        end
        S_OUT: begin
          // hold here while the previous result still waits
          if (out_load) begin
            out_di_r <= rd_ok_r ? di_r : '0;
            out_dq_r <= rd_ok_r ? dq_r : '0;
            out_ei_r <= exi_r;
            out_eq_r <= excess(pv_ok_r ? xq_r : '0, acc_r);
            wp_r <= rd_ptr;
            ep_r <= ep_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_delayed_i = out_di_r;
  assign out_delayed_q = out_dq_r;
  assign out_excess_i = out_ei_r;
  assign out_excess_q = out_eq_r;

  `ASSERT_IMPL(a_busy_not_ready, !(state_r != S_IDLE && in_ready))
  `ASSERT_IMPL(a_state_legal, state_r <= S_OUT)
  `ASSERT_NEXT(a_out_sets, out_load, out_valid_r)
  `ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_eq_r))
endmodule
